// ===== hdl/rfc_pkg.sv =====
// Shared types, constants and the CRC step function of the radio meter frame checker.
package rfc_pkg;

    // Longest frame that is not reported as too long.
    localparam int MAX_FRAME_BYTES = 255;

    // Byte position counter: it stops one past the longest legal frame.
    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    // CRC-16, MSB first, no final inversion.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Frame layout.
    localparam logic [CNT_W-1:0] POS_LENGTH  = 9'd0;
    localparam logic [CNT_W-1:0] POS_TYPE    = 9'd1;
    localparam logic [CNT_W-1:0] POS_ADDR_LO = 9'd2;
    localparam logic [CNT_W-1:0] POS_ADDR_HI = 9'd7;
    localparam logic [CNT_W-1:0] CONTROL_POS = 9'd8;
    localparam logic [7:0]       HEADER_END  = 8'd10;

    // Result status codes.
    localparam logic [1:0] ST_SUCCESS  = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Configuration register map.
    localparam int        ADDR_W  = 3;
    localparam logic      REG_MIN = 1'b0;
    localparam logic      REG_HDR = 1'b1;
    localparam logic [7:0] MIN_FRAME_RESET = 8'd10;
    localparam logic [7:0] HEADER_RESET    = 8'd10;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;

    // Input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  frame_bytes;
        logic [7:0]  length_field;
        logic [7:0]  type_field;
        logic [47:0] meter_address;
        logic [7:0]  control_field;
        logic [7:0]  payload_length;
        logic [15:0] rx_crc_value;
        logic        crc_ok;
        logic        maybe_encrypted;
    } t_out_beat;

    // A classified byte on its way from front to back.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [CNT_W-1:0] pos;
    } t_q_entry;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [7:0] min_frame_bytes;
        logic [7:0] header_bytes;
    } t_cfg;

    // One byte through the CRC, eight shift steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/rfc_front.sv =====
// Front end: accepts frame bytes and tags each with its position in the frame.
module rfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rfc_pkg::t_in_beat i_data,
    input  logic              i_q_full,
    output logic              o_push,
    output rfc_pkg::t_q_entry o_entry
);
    import rfc_pkg::*;

    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] n_pos;

    // Take a beat whenever the queue has room.
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    assign o_entry.data_byte = i_data.data_byte;
    assign o_entry.last_byte = i_data.last_byte;
    assign o_entry.pos       = r_pos;

    // Position counter, saturating one past the longest frame, cleared on the last byte.
    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_data.last_byte) begin
                n_pos = '0;
            end else if (r_pos < CNT_SAT) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== hdl/rfc_queue.sv =====
// Short queue of classified bytes between the front and back ends.
module rfc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rfc_pkg::t_q_entry i_entry,
    output logic              o_full,
    output logic              o_valid,
    output rfc_pkg::t_q_entry o_head,
    input  logic              i_pop
);
    import rfc_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_q_entry          r_slot [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    assign o_full  = (r_count == CNT_QW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rfc_back.sv =====
// Back end: header capture, CRC over the delayed stream and the result register.
module rfc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfc_pkg::t_cfg      i_cfg,
    input  logic               i_head_valid,
    input  rfc_pkg::t_q_entry  i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output rfc_pkg::t_out_beat o_data
);
    import rfc_pkg::*;

    // Frame state.
    logic [15:0] r_crc;
    logic [15:0] r_hold;
    logic [7:0]  r_len;
    logic [7:0]  r_type;
    logic [47:0] r_addr;
    logic [7:0]  r_ctrl;
    logic [15:0] n_crc;
    logic [15:0] n_hold;
    logic [7:0]  n_len;
    logic [7:0]  n_type;
    logic [47:0] n_addr;
    logic [7:0]  n_ctrl;

    // Result register.
    logic      r_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    logic [CNT_W-1:0] w_count;
    logic [2:0]       w_addr_idx;
    logic [7:0]       w_fb;
    logic [15:0]      w_rx_crc;
    logic             w_ok;

    // A last byte waits until the result register is free.
    assign o_pop   = i_head_valid && (!i_head.last_byte || !r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    assign w_count    = (i_head.pos < CNT_SAT) ? i_head.pos + 1'b1 : i_head.pos;
    assign w_addr_idx = 3'(i_head.pos - POS_ADDR_LO);

    // Frame state after this byte.
    always_comb begin
        n_len  = r_len;
        n_type = r_type;
        n_addr = r_addr;
        n_ctrl = r_ctrl;
        if (i_head.pos == POS_LENGTH) begin
            n_len = i_head.data_byte;
        end else if (i_head.pos == POS_TYPE) begin
            n_type = i_head.data_byte;
        end else if (i_head.pos >= POS_ADDR_LO && i_head.pos <= POS_ADDR_HI) begin
            n_addr[{w_addr_idx, 3'b000} +: 8] = i_head.data_byte;
        end else if (i_head.pos == CONTROL_POS) begin
            n_ctrl = i_head.data_byte;
        end
        n_crc  = (i_head.pos >= POS_ADDR_LO) ? crc_feed(r_crc, r_hold[15:8]) : r_crc;
        n_hold = {r_hold[7:0], i_head.data_byte};
    end

    // Result fields for a closing byte.
    assign w_fb     = (w_count > 9'd255) ? 8'hFF : w_count[7:0];
    assign w_rx_crc = (w_count >= 9'd2) ? n_hold : 16'h0000;
    assign w_ok     = (w_count < 9'd3) || (n_crc == w_rx_crc);

    always_comb begin
        if (w_count > CNT_MAX) begin
            n_out.status = ST_TOO_LONG;
        end else if (w_count < {1'b0, i_cfg.min_frame_bytes}
                     || w_count < {1'b0, i_cfg.header_bytes}) begin
            n_out.status = ST_INVALID;
        end else begin
            n_out.status = ST_SUCCESS;
        end
        n_out.frame_bytes     = w_fb;
        n_out.length_field    = n_len;
        n_out.type_field      = n_type;
        n_out.meter_address   = n_addr;
        n_out.control_field   = (w_count > CONTROL_POS) ? n_ctrl : 8'h00;
        n_out.payload_length  = (w_fb > HEADER_END) ? w_fb - HEADER_END : 8'h00;
        n_out.rx_crc_value    = w_rx_crc;
        n_out.crc_ok          = w_ok;
        n_out.maybe_encrypted = (({1'b0, n_len} + 9'd1) != w_count) || !w_ok;
    end

    // Frame state registers, cleared after each frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_hold <= '0;
            r_len  <= '0;
            r_type <= '0;
            r_addr <= '0;
            r_ctrl <= '0;
        end else if (o_pop) begin
            if (i_head.last_byte) begin
                r_crc  <= CRC_INIT;
                r_hold <= '0;
                r_len  <= '0;
                r_type <= '0;
                r_addr <= '0;
                r_ctrl <= '0;
            end else begin
                r_crc  <= n_crc;
                r_hold <= n_hold;
                r_len  <= n_len;
                r_type <= n_type;
                r_addr <= n_addr;
                r_ctrl <= n_ctrl;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_head.last_byte) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last_byte) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/radio_meter_frame_checker_core.sv =====
// Top level of the radio meter frame checker: configuration port, front, queue and back.
// Throughput: one byte per cycle; the front takes a beat whenever the two-entry queue has room.
// Path: a closing byte is pushed into the queue, then popped into the result register once that
// register is free, and its result beat is offered until the receiver takes it.
// Reset: synchronous, active low; frame state and queue are emptied and both
// length registers return to 10.
module radio_meter_frame_checker_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rfc_pkg::t_in_beat          i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rfc_pkg::t_out_beat         o_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rfc_pkg::*;

    t_cfg     r_cfg;
    logic     w_push;
    t_q_entry w_entry;
    logic     w_q_full;
    logic     w_q_valid;
    t_q_entry w_q_head;
    logic     w_pop;
    logic     w_cfg_wr;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_frame_bytes <= MIN_FRAME_RESET;
            r_cfg.header_bytes    <= HEADER_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_MIN: r_cfg.min_frame_bytes <= pwdata[7:0];
                REG_HDR: r_cfg.header_bytes    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MIN: prdata = {24'h0, r_cfg.min_frame_bytes};
            REG_HDR: prdata = {24'h0, r_cfg.header_bytes};
            default: prdata = '0;
        endcase
    end

    rfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    rfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head),
        .i_pop   (w_pop)
    );

    rfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_q_valid),
        .i_head       (w_q_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

    // A too-long frame always reports the saturated byte count.
    a_too_long_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_TOO_LONG) |-> (o_data.frame_bytes == 8'hFF))
        else $error("too_long result without saturated frame_bytes");

    // A CRC mismatch must raise the encryption hint.
    a_crc_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.crc_ok) |-> o_data.maybe_encrypted)
        else $error("crc mismatch without maybe_encrypted");

    // Payload length is only nonzero past the header.
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.payload_length != 8'h00) |-> (o_data.frame_bytes > HEADER_END))
        else $error("payload length on a frame without payload");

    // A closing byte in the queue head never leaves while an untaken result is held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && w_q_valid && w_q_head.last_byte) |-> !w_pop)
        else $error("result register overwritten while stalled");

endmodule

// ===== test/radio_meter_frame_checker_core_tb.sv =====
// Self-checking testbench for the radio meter frame checker core.
module radio_meter_frame_checker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    // Register byte addresses on the configuration port.
    localparam logic [ADDR_W-1:0] MIN_ADDR = {REG_MIN, 2'b00};
    localparam logic [ADDR_W-1:0] HDR_ADDR = {REG_HDR, 2'b00};

    // Long receiver hold-off that lets results back up into the block.
    localparam int LONG_HOLD = 120;
    // Around 1850 beats with their random idle gaps plus result stalls stay far below this.
    localparam int CYCLE_LIMIT = 200000;

    // How a generated frame is shaped.
    typedef enum int {SHAPE_GOOD, SHAPE_NOISE, SHAPE_BAD_CRC, SHAPE_BAD_LEN} t_frame_shape;

    // One queued input beat with the idle cycles to insert before it.
    typedef struct {
        t_in_beat beat;
        int       idle;
    } t_tx_slot;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    t_in_beat            i_data;
    logic                o_valid;
    logic                i_ready;
    t_out_beat           o_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    radio_meter_frame_checker_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_tx_slot  byte_stream[$];
    t_out_beat expected_frames[$];
    t_tx_slot  next_slot;

    // Frame tracking state of the predictor and its copy of the registers.
    logic [7:0]  min_len_cfg;
    logic [7:0]  hdr_len_cfg;
    logic [15:0] crc_acc;
    logic [15:0] tail_bytes;
    int          byte_pos;
    logic [7:0]  hdr_length;
    logic [7:0]  hdr_type;
    logic [47:0] hdr_addr;
    logic [7:0]  hdr_control;

    bit byte_taken;
    bit result_taken;
    bit calm;
    bit hold_request;
    int rx_wait;
    int error_count;
    int cycle_count;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // CRC-16, polynomial 0x1021, processed one bit at a time, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        int i;
        r = acc;
        for (i = 7; i >= 0; i--) begin
            if (r[15] ^ d[i]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    task automatic clear_frame_state();
        crc_acc     = CRC_INIT;
        tail_bytes  = '0;
        byte_pos    = 0;
        hdr_length  = '0;
        hdr_type    = '0;
        hdr_addr    = '0;
        hdr_control = '0;
    endtask

    // Advance the frame state by one accepted byte; on the closing byte, queue the
    // result that the block must give.
    task automatic track_frame_byte(input t_in_beat beat);
        t_out_beat r;
        int cnt;
        int fb;
        if (byte_pos == 0) begin
            hdr_length = beat.data_byte;
        end else if (byte_pos == 1) begin
            hdr_type = beat.data_byte;
        end else if (byte_pos <= 7) begin
            hdr_addr[8*(byte_pos-2) +: 8] = beat.data_byte;
        end else if (byte_pos == 8) begin
            hdr_control = beat.data_byte;
        end
        // The CRC sees each byte once two newer bytes have arrived.
        if (byte_pos >= 2) begin
            crc_acc = crc_byte(crc_acc, tail_bytes[15:8]);
        end
        tail_bytes = {tail_bytes[7:0], beat.data_byte};
        if (byte_pos < MAX_FRAME_BYTES + 1) begin
            byte_pos++;
        end
        if (beat.last_byte) begin
            cnt = byte_pos;
            fb = (cnt > 255) ? 255 : cnt;
            if (cnt > MAX_FRAME_BYTES) begin
                r.status = ST_TOO_LONG;
            end else if (cnt < int'(min_len_cfg) || cnt < int'(hdr_len_cfg)) begin
                r.status = ST_INVALID;
            end else begin
                r.status = ST_SUCCESS;
            end
            r.frame_bytes    = 8'(fb);
            r.length_field   = hdr_length;
            r.type_field     = hdr_type;
            r.meter_address  = hdr_addr;
            r.control_field  = (cnt > int'(CONTROL_POS)) ? hdr_control : 8'd0;
            r.payload_length = (fb > int'(HEADER_END)) ? 8'(fb - int'(HEADER_END)) : 8'd0;
            r.rx_crc_value   = (cnt >= 2) ? tail_bytes : 16'd0;
            r.crc_ok         = (cnt < 3) ? 1'b1 : (crc_acc == r.rx_crc_value);
            r.maybe_encrypted = (int'(hdr_length) + 1 != cnt) || !r.crc_ok;
            expected_frames.push_back(r);
            clear_frame_state();
        end
    endtask

    task automatic flag_error(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    // Compare one result beat against the oldest expected frame result.
    task automatic compare_result(input t_out_beat got);
        t_out_beat want;
        if (expected_frames.size() == 0) begin
            flag_error("result beat with no frame result pending");
        end else begin
            want = expected_frames.pop_front();
            check_field("status", got.status, want.status);
            check_field("frame_bytes", got.frame_bytes, want.frame_bytes);
            check_field("length_field", got.length_field, want.length_field);
            check_field("type_field", got.type_field, want.type_field);
            check_field("meter_address", got.meter_address, want.meter_address);
            check_field("control_field", got.control_field, want.control_field);
            check_field("payload_length", got.payload_length, want.payload_length);
            check_field("rx_crc_value", got.rx_crc_value, want.rx_crc_value);
            check_field("crc_ok", got.crc_ok, want.crc_ok);
            check_field("maybe_encrypted", got.maybe_encrypted, want.maybe_encrypted);
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        t_tx_slot s;
        s.beat.data_byte = data;
        s.beat.last_byte = last;
        s.idle = calm ? 0 : $urandom_range(0, 3);
        byte_stream.push_back(s);
    endtask

    // Build a frame of the given length; well-formed frames carry a matching
    // length byte and a correct trailing CRC.
    task automatic queue_frame(input int len, input t_frame_shape shape);
        logic [7:0]  bytes[$];
        logic [15:0] crc;
        int k;
        for (k = 0; k < len; k++) begin
            bytes.push_back(8'($urandom));
        end
        if (shape != SHAPE_NOISE) begin
            bytes[0] = 8'(len - 1);
            if (shape == SHAPE_BAD_LEN) begin
                bytes[0] = bytes[0] ^ 8'($urandom_range(1, 255));
            end
            if (len >= 3) begin
                crc = CRC_INIT;
                for (k = 0; k < len - 2; k++) begin
                    crc = crc_byte(crc, bytes[k]);
                end
                if (shape == SHAPE_BAD_CRC) begin
                    crc = crc ^ 16'($urandom_range(1, 65535));
                end
                bytes[len-2] = crc[15:8];
                bytes[len-1] = crc[7:0];
            end
        end
        for (k = 0; k < len; k++) begin
            push_byte(bytes[k], k == len - 1);
        end
    endtask

    // Random frames: mostly well-formed, some broken and some pure noise.
    task automatic random_frames(input int n, input int lo_len, input int hi_len);
        int k;
        int r;
        int len;
        t_frame_shape shape;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (hi_len > 0) begin
                len = $urandom_range(lo_len, hi_len);
            end else if (r < 15) begin
                len = $urandom_range(1, 9);
            end else if (r < 90) begin
                len = $urandom_range(10, 40);
            end else begin
                len = $urandom_range(41, 120);
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                shape = SHAPE_GOOD;
            end else if (r < 75) begin
                shape = SHAPE_BAD_CRC;
            end else if (r < 85) begin
                shape = SHAPE_BAD_LEN;
            end else begin
                shape = SHAPE_NOISE;
            end
            queue_frame(len, shape);
        end
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == MIN_ADDR) begin
            min_len_cfg = value;
        end else begin
            hdr_len_cfg = value;
        end
    endtask

    task automatic set_lengths(input logic [7:0] min_len, input logic [7:0] hdr_len);
        write_reg(MIN_ADDR, min_len);
        write_reg(HDR_ADDR, hdr_len);
    endtask

    // Wait until every beat is sent and every frame result has arrived.
    task automatic drain();
        while (byte_stream.size() != 0 || i_valid || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Cycle counter with the run time limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("radio_meter_frame_checker_core verification failed");
            $finish;
        end
    end

    // Monitor: sample accepted input beats into the predictor and check result beats.
    always @(posedge i_clk) begin
        byte_taken   = i_rst_n && i_valid && o_ready;
        result_taken = i_rst_n && o_valid && i_ready;
        if (byte_taken) begin
            track_frame_byte(i_data);
        end
        if (result_taken) begin
            compare_result(o_data);
        end
    end

    // Driver: offer queued beats, holding each until it is accepted.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || byte_taken)) begin
            if (byte_stream.size() == 0) begin
                i_valid <= 1'b0;
            end else if (byte_stream[0].idle > 0) begin
                byte_stream[0].idle = byte_stream[0].idle - 1;
                i_valid <= 1'b0;
            end else begin
                next_slot = byte_stream.pop_front();
                i_data  <= next_slot.beat;
                i_valid <= 1'b1;
            end
        end
    end

    // Receiver: random stalls after each result beat, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_request) begin
            rx_wait = LONG_HOLD;
            hold_request = 1'b0;
        end else if (result_taken) begin
            rx_wait = calm ? 0 : $urandom_range(0, 3);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        calm    = 1'b0;
        hold_request = 1'b0;
        rx_wait = 0;
        error_count = 0;
        cycle_count = 0;
        min_len_cfg = MIN_FRAME_RESET;
        hdr_len_cfg = HEADER_RESET;
        clear_frame_state();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames at reset lengths: one and two byte frames with all-ones and
        // all-zeros bytes, the smallest CRC-checked frame, a frame ending on the control
        // byte, and a full header frame.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        queue_frame(3, SHAPE_GOOD);
        queue_frame(9, SHAPE_GOOD);
        queue_frame(10, SHAPE_GOOD);
        drain();

        // Tiny frames with the receiver held off so that results back up.
        set_lengths(8'd1, 8'd1);
        hold_request = 1'b1;
        random_frames(40, 1, 5);
        drain();

        // Mid-range lengths with no idling on either side.
        set_lengths(8'($urandom_range(2, 30)), 8'($urandom_range(2, 30)));
        calm = 1'b1;
        random_frames(12, 0, 0);
        drain();
        calm = 1'b0;

        // Longest legal frame against the largest minimum length.
        set_lengths(8'd255, 8'd1);
        queue_frame(255, SHAPE_GOOD);
        random_frames(6, 0, 0);
        drain();

        // One byte past the limit against the largest header length.
        set_lengths(8'd1, 8'd255);
        queue_frame(256, SHAPE_GOOD);
        random_frames(6, 0, 0);
        drain();

        // Back to the reset lengths with a clearly overlong frame.
        set_lengths(MIN_FRAME_RESET, HEADER_RESET);
        queue_frame(270, SHAPE_GOOD);
        random_frames(10, 0, 0);
        drain();

        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("radio_meter_frame_checker_core verification clean");
        end else begin
            $display("radio_meter_frame_checker_core verification failed");
        end
        $finish;
    end

endmodule

// ===== radio_meter_frame_checker_core.f =====
hdl/rfc_pkg.sv
hdl/rfc_front.sv
hdl/rfc_queue.sv
hdl/rfc_back.sv
hdl/radio_meter_frame_checker_core.sv
test/radio_meter_frame_checker_core_tb.sv
